// ===== design/irsd_pkg.sv =====
// ----------------------------------------------------------------------------
// irsd_pkg
// Types, codes and the port lookup shared by the IR receiver scan block.
// ----------------------------------------------------------------------------
package irsd_pkg;

  localparam int RECEIVER_COUNT = 4;
  localparam int SEL_W          = $clog2(RECEIVER_COUNT);
  localparam int MASK_W         = 7;

  // input item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_HIT   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_DWELL  = 1'b1;

  localparam logic [7:0] DWELL_RESET = 8'd20;

  // access kinds
  localparam logic [1:0] ACC_NONE   = 2'd0;
  localparam logic [1:0] ACC_TOUCH  = 2'd1;
  localparam logic [1:0] ACC_FOLLOW = 2'd2;
  localparam logic [1:0] ACC_BACK   = 2'd3;

  // headings
  localparam logic [2:0] HEAD_NONE     = 3'd0;
  localparam logic [2:0] HEAD_FORWARD  = 3'd1;
  localparam logic [2:0] HEAD_BACKWARD = 3'd2;
  localparam logic [2:0] HEAD_LEFT     = 3'd3;
  localparam logic [2:0] HEAD_RIGHT    = 3'd4;

  // steering commands
  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_ADJUST = 2'd1;
  localparam logic [1:0] CMD_LOST   = 2'd2;

  localparam logic [2:0] ADJUST_MAX = 3'd5;

  // scan index parked before the first receiver
  localparam logic [2:0] SCAN_PARK = 3'd7;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] hit_shift;
  } in_word_t;

  typedef struct packed {
    logic       result_ready;
    logic [1:0] access_kind;
    logic [2:0] heading;
    logic       sweep_done;
    logic [1:0] receiver_select;
    logic [1:0] steer_command;
  } out_word_t;

  // receiver to port offset, table 3,2,1,0
  function automatic logic [SEL_W-1:0] port_sel(input logic [SEL_W-1:0] idx);
    logic [SEL_W-1:0] sel;
    case (idx)
      2'd0:    sel = 2'd3;
      2'd1:    sel = 2'd2;
      2'd2:    sel = 2'd1;
      default: sel = 2'd0;
    endcase
    return sel;
  endfunction

endpackage

// ===== design/ir_receiver_scan_direction.sv =====
// ----------------------------------------------------------------------------
// ir_receiver_scan_direction
// Four-receiver IR scan with hit mask classification into access kind,
// heading and steering command.
// ----------------------------------------------------------------------------
// The block takes one word per clock unless stalled and returns exactly one
// result word per input word; the scan state lives in a handful of small
// registers updated by short combinational logic. An output register plus a
// one-word skid stage keep the input open while a result waits on a stalled
// output. A tick counts the dwell down while enabled and steps to the next
// receiver on expiry; hits mark the current receiver in the hit mask; each
// completed sweep classifies the mask. Writing one to enable restarts the
// scan and clears the results. cfg_ready is always high; the user must write
// configuration only while idle; the block itself does not enforce this.
module ir_receiver_scan_direction (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  irsd_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output irsd_pkg::out_word_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_data
);

  logic                          enable_r, enable_nxt;
  logic [7:0]                    dwell_ticks_r, dwell_ticks_nxt;
  logic [2:0]                    scan_idx_r, scan_idx_nxt;
  logic [7:0]                    dwell_cnt_r, dwell_cnt_nxt;
  logic [irsd_pkg::MASK_W-1:0]   hit_mask_r, hit_mask_nxt;
  logic [1:0]                    access_r, access_nxt;
  logic [2:0]                    heading_r, heading_nxt;
  logic                          done_r, done_nxt;
  logic [2:0]                    adjust_cnt_r, adjust_cnt_nxt;
  logic [1:0]                    command_r, command_nxt;
  logic [irsd_pkg::SEL_W-1:0]    select_r, select_nxt;

  logic                          out_valid_r, out_valid_nxt;
  irsd_pkg::out_word_t           out_data_r, out_data_nxt;
  logic                          skid_valid_r, skid_valid_nxt;
  irsd_pkg::out_word_t           skid_data_r, skid_data_nxt;

  logic                          in_accept;
  logic                          cfg_wr;
  logic [2:0]                    idx_inc;
  logic [irsd_pkg::MASK_W-1:0]   hit_bits;
  irsd_pkg::out_word_t           result;

  // classification of the current mask
  logic [irsd_pkg::MASK_W-1:0]   cls_in;
  logic [3:0]                    cls_s;
  logic [1:0]                    cls_acc;
  logic [2:0]                    cls_head;
  logic [2:0]                    cls_adj;
  logic [1:0]                    cls_cmd;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign idx_inc  = scan_idx_r + 3'd1;
  assign hit_bits = irsd_pkg::MASK_W'(irsd_pkg::MASK_W'(1) << scan_idx_r[1:0])
                    << in_data.hit_shift;

  always_comb begin
    cls_in = hit_mask_r;
    if ((cls_in & 7'h70) != 7'd0) begin
      cls_s   = cls_in[3:0] | {1'b0, cls_in[6:4]};
      cls_acc = irsd_pkg::ACC_TOUCH;
    end else if ((cls_in & 7'h07) != 7'd0) begin
      cls_s   = {1'b0, cls_in[2:0]};
      cls_acc = irsd_pkg::ACC_FOLLOW;
    end else if (cls_in[3]) begin
      cls_s   = 4'h8;
      cls_acc = irsd_pkg::ACC_BACK;
    end else begin
      cls_s   = 4'h0;
      cls_acc = irsd_pkg::ACC_NONE;
    end

    case (cls_s)
      4'd1, 4'd5:       cls_head = irsd_pkg::HEAD_LEFT;
      4'd2, 4'd6:       cls_head = irsd_pkg::HEAD_RIGHT;
      4'd3, 4'd4, 4'd7: cls_head = irsd_pkg::HEAD_FORWARD;
      4'd8:             cls_head = irsd_pkg::HEAD_BACKWARD;
      default:          cls_head = irsd_pkg::HEAD_NONE;
    endcase

    // adjust counter saturates, lost keeps it, anything else clears it
    cls_adj = adjust_cnt_r;
    cls_cmd = irsd_pkg::CMD_NONE;
    if (cls_s[1:0] != 2'd0) begin
      if (adjust_cnt_r < irsd_pkg::ADJUST_MAX) begin
        cls_adj = adjust_cnt_r + 3'd1;
      end
      if (cls_adj >= irsd_pkg::ADJUST_MAX) begin
        cls_cmd = irsd_pkg::CMD_ADJUST;
      end
    end else if (cls_s == 4'd0) begin
      cls_cmd = irsd_pkg::CMD_LOST;
    end else begin
      cls_adj = 3'd0;
    end
  end

  always_comb begin
    enable_nxt      = enable_r;
    dwell_ticks_nxt = dwell_ticks_r;
    scan_idx_nxt    = scan_idx_r;
    dwell_cnt_nxt   = dwell_cnt_r;
    hit_mask_nxt    = hit_mask_r;
    access_nxt      = access_r;
    heading_nxt     = heading_r;
    done_nxt        = done_r;
    adjust_cnt_nxt  = adjust_cnt_r;
    command_nxt     = command_r;
    select_nxt      = select_r;

    if (cfg_wr) begin
      case (cfg_index)
        irsd_pkg::CFG_ENABLE: begin
          enable_nxt = cfg_data[0];
          if (cfg_data[0]) begin
            scan_idx_nxt   = irsd_pkg::SCAN_PARK;
            dwell_cnt_nxt  = 8'd0;
            hit_mask_nxt   = '0;
            adjust_cnt_nxt = 3'd0;
            access_nxt     = irsd_pkg::ACC_NONE;
            heading_nxt    = irsd_pkg::HEAD_NONE;
            done_nxt       = 1'b0;
            command_nxt    = irsd_pkg::CMD_NONE;
          end
        end
        default: begin
          dwell_ticks_nxt = cfg_data;
        end
      endcase
    end else if (in_accept) begin
      case (in_data.kind)
        irsd_pkg::KIND_TICK: begin
          if (enable_r) begin
            if (dwell_cnt_r != 8'd0) begin
              dwell_cnt_nxt = dwell_cnt_r - 8'd1;
            end else begin
              // stepping past the last receiver ends the sweep
              if (idx_inc[2]) begin
                scan_idx_nxt   = 3'd0;
                hit_mask_nxt   = '0;
                done_nxt       = 1'b1;
                access_nxt     = cls_acc;
                heading_nxt    = cls_head;
                adjust_cnt_nxt = cls_adj;
                command_nxt    = cls_cmd;
              end else begin
                scan_idx_nxt = idx_inc;
              end
              select_nxt    = irsd_pkg::port_sel(scan_idx_nxt[1:0]);
              dwell_cnt_nxt = dwell_ticks_r;
            end
          end
        end
        irsd_pkg::KIND_HIT: begin
          if (!scan_idx_r[2]) begin
            hit_mask_nxt = hit_mask_r | hit_bits;
          end
        end
        irsd_pkg::KIND_CLEAR: begin
          access_nxt  = irsd_pkg::ACC_NONE;
          heading_nxt = irsd_pkg::HEAD_NONE;
          done_nxt    = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result.result_ready    = (access_nxt != irsd_pkg::ACC_NONE);
    result.access_kind     = access_nxt;
    result.heading         = heading_nxt;
    result.sweep_done      = done_nxt;
    result.receiver_select = select_nxt;
    result.steer_command   = command_nxt;
  end

  // output register with a one-word skid stage
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || !out_stall) begin
      out_valid_nxt  = skid_valid_r || in_accept;
      out_data_nxt   = skid_valid_r ? skid_data_r : result;
      skid_valid_nxt = 1'b0;
    end else if (in_accept) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b0;
      dwell_ticks_r <= irsd_pkg::DWELL_RESET;
      scan_idx_r    <= 3'd0;
      dwell_cnt_r   <= 8'd0;
      hit_mask_r    <= '0;
      access_r      <= irsd_pkg::ACC_NONE;
      heading_r     <= irsd_pkg::HEAD_NONE;
      done_r        <= 1'b0;
      adjust_cnt_r  <= 3'd0;
      command_r     <= irsd_pkg::CMD_NONE;
      select_r      <= '0;
      out_valid_r   <= 1'b0;
      skid_valid_r  <= 1'b0;
    end else begin
      enable_r      <= enable_nxt;
      dwell_ticks_r <= dwell_ticks_nxt;
      scan_idx_r    <= scan_idx_nxt;
      dwell_cnt_r   <= dwell_cnt_nxt;
      hit_mask_r    <= hit_mask_nxt;
      access_r      <= access_nxt;
      heading_r     <= heading_nxt;
      done_r        <= done_nxt;
      adjust_cnt_r  <= adjust_cnt_nxt;
      command_r     <= command_nxt;
      select_r      <= select_nxt;
      out_valid_r   <= out_valid_nxt;
      skid_valid_r  <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held without an output word");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!skid_valid_r && $past(skid_valid_r == 1'b0) && skid_valid_nxt) |->
      (out_valid_r && out_stall))
    else $error("skid filled while output was free");

  a_scan_idx_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !(scan_idx_r == 3'd4 || scan_idx_r == 3'd5 || scan_idx_r == 3'd6))
    else $error("scan index out of range");

  a_adjust_sat: assert property (@(posedge clk) disable iff (!rst_n)
    adjust_cnt_r <= irsd_pkg::ADJUST_MAX)
    else $error("adjust counter beyond saturation");

  a_ready_matches_access: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      (out_data_r.result_ready == (out_data_r.access_kind != irsd_pkg::ACC_NONE)))
    else $error("result_ready disagrees with access kind");
`endif

endmodule
